FILE: src/ghash_accumulator_core_defines.svh
// ----------------------------------------------------------------------------
// GHASH accumulator assertion macros
// Shared concurrent assertion wrappers for the GHASH accumulator checkers.
// ----------------------------------------------------------------------------
`ifndef GHASH_ACCUMULATOR_CORE_DEFINES_SVH
`define GHASH_ACCUMULATOR_CORE_DEFINES_SVH

// Clocked assertion, switched off while reset is asserted.
`define GA_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define GA_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/ghash_acc_pkg.sv
// ----------------------------------------------------------------------------
// GHASH accumulator package
// Widths, register indexes, queue entry and engine state types.
// ----------------------------------------------------------------------------
package ghash_acc_pkg;

  localparam int HALF_W       = 64;
  localparam int BLOCK_W      = 128;
  localparam int BLOCK_BYTES  = 16;
  localparam int NBYTES_W     = 5;
  localparam int IN_TDATA_W   = 136;
  localparam int OUT_TDATA_W  = 128;
  localparam int CFG_INDEX_W  = 1;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HI = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LO = 1'b1;

  // Multiplier digit: bits of the multiplicand consumed per cycle
  localparam int DIGIT_W = 8;
  localparam int DIGITS  = BLOCK_W / DIGIT_W;
  localparam int CNT_W   = $clog2(DIGITS);

  // Reduction byte for x^128 + x^7 + x^2 + x + 1 in reflected form
  localparam logic [7:0] REDUCE_BYTE = 8'hE1;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic [BLOCK_W-1:0] blk;      // padded block, field bit 0 in bit 127
    logic               restart;  // clear accumulator first
    logic               skip;     // zero valid bytes: no multiply
  } q_entry_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_RUN,
    ENG_DONE
  } eng_state_t;

endpackage

FILE: src/ghash_accumulator_core.sv
// Flow: the idle engine pops a queued block, multiplies it in RUN and loads the result
// from DONE into the output register; a block with zero valid bytes skips RUN.
// The engine consumes 8 bits of the multiplicand per cycle and takes the next block only
// after DONE has loaded the result, which waits while the output is stalled.
// The input queue takes further blocks while the engine works.
// Reset: synchronous active-low; clears hash key, accumulator, queue and output valid.
// ----------------------------------------------------------------------------
// GHASH accumulator core
// Padded-block GHASH multiply-accumulate with a configurable hash key.
// ----------------------------------------------------------------------------
module ghash_accumulator_core #(
  parameter int QUEUE_DEPTH = ghash_acc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // [63:0] block_hi, [127:64] block_lo, [132:128] valid_bytes, [135:133] zero
  input  logic [ghash_acc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] restart
  input  logic [0:0]                             in_tuser,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // [63:0] hash_hi, [127:64] hash_lo
  output logic [ghash_acc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic                                   cfg_we,
  input  logic [ghash_acc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ghash_acc_pkg::HALF_W-1:0]       cfg_wdata
);

  logic [ghash_acc_pkg::HALF_W-1:0]  key_hi_r;
  logic [ghash_acc_pkg::HALF_W-1:0]  key_lo_r;
  logic [ghash_acc_pkg::BLOCK_W-1:0] out_hash;

  ghash_acc_pkg::q_entry_t push_entry;
  ghash_acc_pkg::q_entry_t pop_entry;
  logic                    q_push;
  logic                    q_full;
  logic                    q_pop;
  logic                    q_nonempty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ghash_acc_pkg::REG_KEY_HI: key_hi_r <= cfg_wdata;
        ghash_acc_pkg::REG_KEY_LO: key_lo_r <= cfg_wdata;
        default: key_hi_r <= key_hi_r;
      endcase
    end
  end

  ghash_acc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  ghash_acc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .nonempty   (q_nonempty)
  );

  ghash_acc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_nonempty),
    .q_entry   (pop_entry),
    .q_pop     (q_pop),
    .hash_key  ({key_hi_r, key_lo_r}),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_hash  (out_hash)
  );

  assign out_tdata = {out_hash[ghash_acc_pkg::HALF_W-1:0],
                      out_hash[ghash_acc_pkg::BLOCK_W-1:ghash_acc_pkg::HALF_W]};

endmodule

FILE: src/ghash_acc_front.sv
// ----------------------------------------------------------------------------
// GHASH accumulator front end
// Unpacks an input transfer, pads the block and classifies it for the queue.
// ----------------------------------------------------------------------------
module ghash_acc_front (
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [ghash_acc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [0:0]                            in_tuser,
  input  logic                                  q_full,
  output logic                                  q_push,
  output ghash_acc_pkg::q_entry_t               q_entry
);

  logic [ghash_acc_pkg::BLOCK_W-1:0]  blk;
  logic [ghash_acc_pkg::NBYTES_W-1:0] nbytes;
  logic [ghash_acc_pkg::NBYTES_W-1:0] nsat;
  logic [ghash_acc_pkg::BLOCK_W-1:0]  padded;

  assign blk    = {in_tdata[ghash_acc_pkg::HALF_W-1:0],
                   in_tdata[ghash_acc_pkg::BLOCK_W-1:ghash_acc_pkg::HALF_W]};
  assign nbytes = in_tdata[ghash_acc_pkg::BLOCK_W +: ghash_acc_pkg::NBYTES_W];

  // saturate counts above a full block
  assign nsat = (nbytes > ghash_acc_pkg::NBYTES_W'(ghash_acc_pkg::BLOCK_BYTES)) ?
                ghash_acc_pkg::NBYTES_W'(ghash_acc_pkg::BLOCK_BYTES) : nbytes;

  always_comb begin
    padded = '0;
    for (int b = 0; b < ghash_acc_pkg::BLOCK_BYTES; b++) begin
      if (ghash_acc_pkg::NBYTES_W'(b) < nsat) begin
        padded[ghash_acc_pkg::BLOCK_W-1-8*b -: 8] = blk[ghash_acc_pkg::BLOCK_W-1-8*b -: 8];
      end
    end
  end

  assign q_entry.blk     = padded;
  assign q_entry.restart = in_tuser[0];
  assign q_entry.skip    = (nbytes == '0);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

endmodule

FILE: src/ghash_acc_fifo.sv
// ----------------------------------------------------------------------------
// GHASH accumulator block queue
// Short register queue decoupling the front end from the multiply engine.
// ----------------------------------------------------------------------------
module ghash_acc_fifo #(
  parameter int DEPTH = ghash_acc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  ghash_acc_pkg::q_entry_t  push_entry,
  output logic                     full,
  input  logic                     pop,
  output ghash_acc_pkg::q_entry_t  pop_entry,
  output logic                     nonempty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ghash_acc_pkg::q_entry_t slots [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign nonempty  = (cnt_r != '0);
  assign pop_entry = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: src/ghash_acc_back.sv
// ----------------------------------------------------------------------------
// GHASH accumulator multiply engine
// Digit-serial GF(2^128) multiply-accumulate with an output register.
// ----------------------------------------------------------------------------
module ghash_acc_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  input  ghash_acc_pkg::q_entry_t               q_entry,
  output logic                                  q_pop,
  input  logic [ghash_acc_pkg::BLOCK_W-1:0]     hash_key,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ghash_acc_pkg::BLOCK_W-1:0]     out_hash
);

  // multiply by x in the reflected field
  function automatic logic [ghash_acc_pkg::BLOCK_W-1:0] gf_shift(
    input logic [ghash_acc_pkg::BLOCK_W-1:0] v
  );
    logic [ghash_acc_pkg::BLOCK_W-1:0] s;
    s = {1'b0, v[ghash_acc_pkg::BLOCK_W-1:1]};
    if (v[0]) begin
      s[ghash_acc_pkg::BLOCK_W-1 -: 8] = s[ghash_acc_pkg::BLOCK_W-1 -: 8] ^
                                        ghash_acc_pkg::REDUCE_BYTE;
    end
    return s;
  endfunction

  localparam logic [ghash_acc_pkg::CNT_W-1:0] LAST_DIGIT =
    ghash_acc_pkg::CNT_W'(ghash_acc_pkg::DIGITS - 1);

  ghash_acc_pkg::eng_state_t state_r, state_nxt;

  logic [ghash_acc_pkg::BLOCK_W-1:0] acc_r;
  logic [ghash_acc_pkg::BLOCK_W-1:0] x_r;
  logic [ghash_acc_pkg::BLOCK_W-1:0] v_r;
  logic [ghash_acc_pkg::BLOCK_W-1:0] z_r;
  logic [ghash_acc_pkg::CNT_W-1:0]   cnt_r;
  logic                              out_valid_r;
  logic [ghash_acc_pkg::BLOCK_W-1:0] out_hash_r;

  logic [ghash_acc_pkg::BLOCK_W-1:0] base;
  logic [ghash_acc_pkg::BLOCK_W-1:0] z_step;
  logic [ghash_acc_pkg::BLOCK_W-1:0] v_step;
  logic                              out_free;
  logic                              run;
  logic                              last;
  logic                              load_out;

  assign base     = q_entry.restart ? '0 : acc_r;
  assign out_free = !out_valid_r || out_ready;

  // one digit of the multiplicand, field bit 0 (register bit 127) first
  always_comb begin
    z_step = z_r;
    v_step = v_r;
    for (int j = 0; j < ghash_acc_pkg::DIGIT_W; j++) begin
      if (x_r[ghash_acc_pkg::BLOCK_W-1-j]) begin
        z_step = z_step ^ v_step;
      end
      v_step = gf_shift(v_step);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ghash_acc_pkg::ENG_IDLE: begin
        if (q_valid) begin
          state_nxt = q_entry.skip ? ghash_acc_pkg::ENG_DONE : ghash_acc_pkg::ENG_RUN;
        end
      end
      ghash_acc_pkg::ENG_RUN: begin
        if (cnt_r == LAST_DIGIT) begin
          state_nxt = ghash_acc_pkg::ENG_DONE;
        end
      end
      ghash_acc_pkg::ENG_DONE: begin
        if (out_free) begin
          state_nxt = ghash_acc_pkg::ENG_IDLE;
        end
      end
      default: state_nxt = ghash_acc_pkg::ENG_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    run      = 1'b0;
    last     = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ghash_acc_pkg::ENG_IDLE: q_pop    = q_valid;
      ghash_acc_pkg::ENG_RUN: begin
        run  = 1'b1;
        last = (cnt_r == LAST_DIGIT);
      end
      ghash_acc_pkg::ENG_DONE: load_out = out_free;
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ghash_acc_pkg::ENG_IDLE;
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop && q_entry.skip) begin
        acc_r <= base;
      end else if (last) begin
        acc_r <= z_step;
      end
      if (q_pop) begin
        cnt_r <= '0;
      end else if (run) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_r <= base ^ q_entry.blk;
      v_r <= hash_key;
      z_r <= '0;
    end else if (run) begin
      x_r <= x_r << ghash_acc_pkg::DIGIT_W;
      v_r <= v_step;
      z_r <= z_step;
    end
    if (load_out) begin
      out_hash_r <= acc_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hash  = out_hash_r;

endmodule

FILE: src/ghash_acc_checker.sv
// ----------------------------------------------------------------------------
// GHASH accumulator port checker
// Observes the top-level ports and flags handshake and reset slips.
// ----------------------------------------------------------------------------
`include "ghash_accumulator_core_defines.svh"

module ghash_acc_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_tready,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [ghash_acc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result transfer holds
  `GA_ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "out_tvalid dropped while stalled")
  `GA_ASSERT_CLK(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata), "out_tdata changed while stalled")
  // reset empties the output register and the queue
  `GA_ASSERT_RST(a_rst_out, clk, !rst_n |=> !out_tvalid, "result valid straight after reset")
  `GA_ASSERT_RST(a_rst_in, clk, !rst_n |=> in_tready, "input not ready straight after reset")

endmodule

bind ghash_accumulator_core ghash_acc_checker u_ghash_acc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: test/ghash_accumulator_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GHASH accumulator core testbench
// Drives data blocks and byte counts through the stream ports under several hash keys,
// predicts every updated accumulator with a bit-serial GF(2^128) multiplier
// and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module ghash_accumulator_core_test;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 830;
  localparam int KEY_PERIOD   = 140;
  localparam int CALM_ITEMS   = 100;
  localparam int LONG_HOLD    = 300;
  localparam int DIR_ROWS     = 20;

  localparam logic [63:0] Z64   = 64'h0;
  localparam logic [63:0] ONES  = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] UNIT  = 64'h8000_0000_0000_0000;  // field element 1
  localparam logic [63:0] PAT_H = 64'h0123_4567_89ab_cdef;
  localparam logic [63:0] PAT_L = 64'hfedc_ba98_7654_3210;

  typedef struct packed {
    logic [63:0] hash_hi;
    logic [63:0] hash_lo;
  } hash_t;

  typedef struct packed {
    bit          new_key;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] blk_hi;
    logic [63:0] blk_lo;
    logic [4:0]  nbytes;
    logic        restart;
    bit          fixed;
    logic [63:0] exp_hi;
    logic [63:0] exp_lo;
  } block_row_t;

  // new_key, key hi/lo, block hi/lo, bytes, restart, fixed, expected hi/lo
  block_row_t dir_rows [DIR_ROWS] = '{
    // key zero from reset: every product vanishes
    '{0, Z64, Z64, ONES, ONES, 16, 1, 1, Z64, Z64},
    '{0, Z64, Z64, PAT_H, PAT_L, 0, 0, 1, Z64, Z64},
    '{0, Z64, Z64, PAT_H, PAT_L, 31, 0, 1, Z64, Z64},
    // unit key: the accumulator is just the XOR of the padded blocks
    '{1, UNIT, Z64, ONES, ONES, 16, 1, 1, ONES, ONES},
    '{0, Z64, Z64, PAT_H, PAT_L, 0, 0, 1, ONES, ONES},
    '{0, Z64, Z64, Z64, Z64, 0, 1, 1, Z64, Z64},
    '{0, Z64, Z64, ONES, ONES, 1, 1, 1, 64'hff00_0000_0000_0000, Z64},
    '{0, Z64, Z64, ONES, ONES, 8, 1, 1, ONES, Z64},
    '{0, Z64, Z64, ONES, ONES, 9, 1, 1, ONES, 64'hff00_0000_0000_0000},
    '{0, Z64, Z64, ONES, ONES, 15, 1, 1, ONES, 64'hffff_ffff_ffff_ff00},
    '{0, Z64, Z64, ONES, ONES, 17, 1, 1, ONES, ONES},
    '{0, Z64, Z64, ONES, ONES, 31, 0, 1, Z64, Z64},
    '{0, Z64, Z64, PAT_H, PAT_L, 16, 0, 1, PAT_H, PAT_L},
    // all-ones key
    '{1, ONES, ONES, ONES, ONES, 16, 1, 0, Z64, Z64},
    '{0, Z64, Z64, PAT_H, PAT_L, 5, 0, 0, Z64, Z64},
    '{0, Z64, Z64, Z64, Z64, 16, 0, 0, Z64, Z64},
    '{0, Z64, Z64, PAT_H, PAT_L, 0, 0, 0, Z64, Z64},
    // key with only the top field bit set
    '{1, Z64, 64'h1, UNIT, Z64, 16, 1, 1, Z64, 64'h1},
    '{0, Z64, Z64, Z64, 64'h1, 16, 1, 0, Z64, Z64},
    '{0, Z64, Z64, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 12, 0, 0, Z64, Z64}
  };

  logic                                  clk = 1'b0;
  logic                                  rst_n = 1'b0;
  logic [ghash_acc_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [0:0]                            in_tuser = '0;
  logic                                  in_tvalid = 1'b0;
  logic                                  in_tready;
  logic [ghash_acc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                                  out_tvalid;
  logic                                  out_tready = 1'b1;
  logic                                  cfg_we = 1'b0;
  logic [ghash_acc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ghash_acc_pkg::HALF_W-1:0]      cfg_wdata = '0;

  logic [127:0] acc_model = '0;
  logic [127:0] key_model = '0;
  hash_t        hash_expected [$];

  int  error_count = 0;
  int  sent_count = 0;
  int  result_count = 0;
  int  key_settings = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;
  bit  long_hold_req = 1'b0;

  ghash_accumulator_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Bit-reflected product: field bit 0 is the MSB, reduction folds in 0xE1.
  function automatic logic [127:0] field_multiply(input logic [127:0] x,
                                                  input logic [127:0] h);
    logic [127:0] prod;
    logic [127:0] v;
    prod = '0;
    v = h;
    for (int i = 0; i < 128; i++) begin
      if (x[127-i]) prod ^= v;
      if (v[0]) v = (v >> 1) ^ {8'he1, 120'b0};
      else v = v >> 1;
    end
    return prod;
  endfunction

  function automatic logic [127:0] absorb_block(input logic [63:0] hi, input logic [63:0] lo,
                                                input logic [4:0] nb, input logic rs);
    logic [127:0] padded;
    int unsigned  n;
    n = (nb > 16) ? 16 : nb;
    if (rs) acc_model = '0;
    // zero bytes: no multiply, accumulator passes through
    if (n != 0) begin
      padded = {hi, lo} & (~128'd0 << (128 - 8 * n));
      acc_model = field_multiply(acc_model ^ padded, key_model);
    end
    return acc_model;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                            input logic [4:0] nb, input logic rs,
                            input bit fixed, input hash_t fixed_hash);
    logic [127:0] predicted;
    in_tdata  <= {3'b000, nb, lo, hi};
    in_tuser  <= rs;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted = absorb_block(hi, lo, nb, rs);
    hash_expected.push_back(fixed ? fixed_hash : hash_t'(predicted));
    sent_count++;
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int g;
    if (!calm && $urandom_range(0, 3) == 0) begin
      g = $urandom_range(1, 9);
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Hold the input off until every outstanding hash has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (hash_expected.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
    cfg_we    <= 1'b1;
    cfg_index <= ghash_acc_pkg::REG_KEY_HI;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_index <= ghash_acc_pkg::REG_KEY_LO;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_we <= 1'b0;
    key_model = {hi, lo};
    key_settings++;
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    int hold_left;
    bit ready_next;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_tready <= ready_next;
    end
  end

  always @(posedge clk) begin
    hash_t got;
    hash_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.hash_hi = out_tdata[63:0];
      got.hash_lo = out_tdata[127:64];
      result_count++;
      if (hash_expected.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, got %h %h",
                 $time, got.hash_hi, got.hash_lo);
      end else begin
        want = hash_expected.pop_front();
        if (got.hash_hi !== want.hash_hi) begin
          error_count++;
          $display("%0t: hash_hi expected %h, got %h", $time, want.hash_hi, got.hash_hi);
        end
        if (got.hash_lo !== want.hash_lo) begin
          error_count++;
          $display("%0t: hash_lo expected %h, got %h", $time, want.hash_lo, got.hash_lo);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d hashes outstanding", $time, hash_expected.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int          msg_left;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] khi;
    logic [63:0] klo;
    logic [4:0]  nb;
    logic        rs;
    msg_left = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].new_key) begin
        drain();
        write_key(dir_rows[r].key_hi, dir_rows[r].key_lo);
      end
      sender_gap();
      send_block(dir_rows[r].blk_hi, dir_rows[r].blk_lo, dir_rows[r].nbytes,
                 dir_rows[r].restart, dir_rows[r].fixed,
                 '{dir_rows[r].exp_hi, dir_rows[r].exp_lo});
    end

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % KEY_PERIOD == 0) begin
        drain();
        case ($urandom_range(0, 5))
          0: begin khi = Z64; klo = Z64; end
          1: begin khi = ONES; klo = ONES; end
          2: begin khi = UNIT; klo = Z64; end
          default: begin khi = {$urandom, $urandom}; klo = {$urandom, $urandom}; end
        endcase
        write_key(khi, klo);
        msg_left = 0;
      end
      if (k == 250) long_hold_req = 1'b1;
      if (k == 500) drain();
      if (k == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;

      // Mostly whole messages: restart on the first block, full blocks,
      // a tail of 1 to 16 bytes; the rest is loose blocks with any count.
      if (msg_left == 0 && $urandom_range(0, 4) == 0) begin
        nb = 5'($urandom_range(0, 31));
        rs = 1'($urandom_range(0, 1));
      end else begin
        if (msg_left == 0) begin
          msg_left = $urandom_range(1, 8);
          rs = 1'b1;
        end else begin
          rs = 1'b0;
        end
        msg_left--;
        nb = (msg_left == 0) ? 5'($urandom_range(1, 16)) : 5'd16;
      end
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      sender_gap();
      send_block(hi, lo, nb, rs, 1'b0, '0);
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Sent %0d blocks (%0d from the table) under %0d key settings;",
             sent_count, DIR_ROWS, key_settings);
    $display("checked %0d hash results, %0d mismatches.", result_count, error_count);
    if (error_count == 0 && hash_expected.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/ghash_acc_pkg.sv
src/ghash_acc_front.sv
src/ghash_acc_fifo.sv
src/ghash_acc_back.sv
src/ghash_accumulator_core.sv
src/ghash_acc_checker.sv
test/ghash_accumulator_core_test.sv
